// ===== design/mfd_pkg.sv =====
// Shared types and constants for the message frame deframer.
// No dependencies; imported by mfd_front, mfd_fifo, message_frame_deframer and the testbench.
`timescale 1ns / 1ps

package mfd_pkg;

  // flags byte bit positions
  localparam int unsigned FLAG_MORE_BIT = 0;
  localparam int unsigned FLAG_LONG_BIT = 1;
  localparam int unsigned FLAG_CMD_BIT  = 2;

  // result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_OVER  = 2'd2;

  localparam logic [15:0] MAX_LEN_RESET = 16'd256;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] frame_len;
    logic        is_command;
    logic        last_of_frame;
    logic        last_of_message;
  } mfd_result_t;

endpackage

// ===== design/mfd_front.sv =====
// Front end of the deframer: parses flags, size and body bytes one per cycle
// and emits classified result records. Depends on mfd_pkg.
`timescale 1ns / 1ps

module mfd_front import mfd_pkg::*; #(
  parameter int unsigned LEN_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_vld,
  input  logic [7:0]  rx_byte,
  input  logic [15:0] max_len,
  output logic        res_vld,
  output mfd_result_t res
);

  // size accumulator keeps at least 16 bits so the 16-bit reported length is exact; larger sizes saturate to FFFF
  localparam int unsigned AW = (LEN_BITS > 16) ? LEN_BITS : 16;
  localparam logic [AW-1:0] CAP = AW'((64'd1 << LEN_BITS) - 64'd1);

  localparam logic [1:0] PH_FLAGS = 2'd0;
  localparam logic [1:0] PH_SIZE  = 2'd1;
  localparam logic [1:0] PH_BODY  = 2'd2;

  logic [1:0]          phase_r, phase_nxt;
  logic [2:0]          flags_r, flags_nxt;
  logic [3:0]          size_left_r, size_left_nxt;
  logic [AW-1:0]       acc_r, acc_nxt;
  logic                ovf_r, ovf_nxt;
  logic [LEN_BITS-1:0] body_left_r, body_left_nxt;
  logic                halted_r, halted_nxt;

  logic [AW-1:0] acc_sh;
  logic          ovf_sh;
  logic [AW-1:0] limit;
  logic [15:0]   len_sat;
  logic          msg_end;

  always_comb begin
    acc_sh  = {acc_r[AW-9:0], rx_byte};
    ovf_sh  = ovf_r | (acc_r[AW-1 -: 8] != 8'd0);
    limit   = (AW'(max_len) > CAP) ? CAP : AW'(max_len);
    len_sat = (ovf_sh || ((acc_sh >> 16) != '0)) ? 16'hFFFF : acc_sh[15:0];
    msg_end = ~flags_r[FLAG_MORE_BIT];

    phase_nxt     = phase_r;
    flags_nxt     = flags_r;
    size_left_nxt = size_left_r;
    acc_nxt       = acc_r;
    ovf_nxt       = ovf_r;
    body_left_nxt = body_left_r;
    halted_nxt    = halted_r;

    res_vld             = 1'b0;
    res.kind            = KIND_BYTE;
    res.data_byte       = 8'd0;
    res.frame_len       = acc_r[15:0];
    res.is_command      = flags_r[FLAG_CMD_BIT];
    res.last_of_frame   = 1'b0;
    res.last_of_message = 1'b0;

    if (byte_vld && !halted_r) begin
      unique case (phase_r)
        PH_FLAGS: begin
          flags_nxt     = rx_byte[2:0];
          size_left_nxt = rx_byte[FLAG_LONG_BIT] ? 4'd8 : 4'd1;
          acc_nxt       = '0;
          ovf_nxt       = 1'b0;
          phase_nxt     = PH_SIZE;
        end
        PH_SIZE: begin
          acc_nxt = acc_sh;
          ovf_nxt = ovf_sh;
          if (size_left_r > 4'd1) begin
            size_left_nxt = size_left_r - 4'd1;
          end else begin
            size_left_nxt = 4'd0;
            if (ovf_sh || (acc_sh > limit)) begin
              halted_nxt    = 1'b1;
              phase_nxt     = PH_FLAGS;
              res_vld       = 1'b1;
              res.kind      = KIND_OVER;
              res.frame_len = len_sat;
            end else if (acc_sh == '0) begin
              phase_nxt           = PH_FLAGS;
              res_vld             = 1'b1;
              res.kind            = KIND_EMPTY;
              res.frame_len       = 16'd0;
              res.last_of_frame   = 1'b1;
              res.last_of_message = msg_end;
            end else begin
              body_left_nxt = acc_sh[LEN_BITS-1:0];
              phase_nxt     = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          res_vld       = 1'b1;
          res.data_byte = rx_byte;
          if (body_left_r <= LEN_BITS'(1)) begin
            body_left_nxt       = '0;
            phase_nxt           = PH_FLAGS;
            res.last_of_frame   = 1'b1;
            res.last_of_message = msg_end;
          end else begin
            body_left_nxt = body_left_r - LEN_BITS'(1);
          end
        end
        default: begin
          phase_nxt = PH_FLAGS;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FLAGS;
      flags_r     <= 3'd0;
      size_left_r <= 4'd0;
      acc_r       <= '0;
      ovf_r       <= 1'b0;
      body_left_r <= '0;
      halted_r    <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      flags_r     <= flags_nxt;
      size_left_r <= size_left_nxt;
      acc_r       <= acc_nxt;
      ovf_r       <= ovf_nxt;
      body_left_r <= body_left_nxt;
      halted_r    <= halted_nxt;
    end
  end

endmodule

// ===== design/mfd_fifo.sv =====
// Result queue between the parser and the output port; holds result beats.
// Depends on mfd_pkg.
`timescale 1ns / 1ps

module mfd_fifo import mfd_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  mfd_result_t wr_data,
  input  logic        rd_en,
  output mfd_result_t rd_data,
  output logic        full,
  output logic        empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mfd_result_t mem [DEPTH];

  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== design/message_frame_deframer.sv =====
// Top level of the message frame deframer: limit register, parser, result queue.
// Depends on mfd_pkg, mfd_front and mfd_fifo.
//
// Usage:
//   Input channel: drive in_rx_byte with in_push high; a byte is taken on a
//   clock edge where in_full is low. One byte per cycle can be taken.
//   Result channel: while out_empty is low the oldest result is on the out_
//   ports; it is taken on an edge where out_pop is high.
//   Config: cfg_wr_en with cfg_wr_data loads the frame length limit
//   (reset 256); write it only while the block is idle.
//   Results: a result is written into the queue on the edge that takes the
//   byte that causes it. Throughput: one byte and at most one result per
//   cycle while in_full is low.
//   Stall: results collect in a FIFO_DEPTH-entry queue; in_full rises when
//   it is full, and bytes are held off until the receiver pops.
//   Reset (rst_n low, synchronous): parser returns to expecting a flags
//   byte, the queue empties, the error halt clears and the limit goes to 256.
//   After an oversize error every further byte is taken and dropped until
//   reset.
`timescale 1ns / 1ps

module message_frame_deframer import mfd_pkg::*; #(
  parameter int unsigned LEN_BITS   = 16,
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_rx_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [15:0] out_frame_len,
  output logic        out_is_command,
  output logic        out_last_of_frame,
  output logic        out_last_of_message,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic [15:0] max_len_r;
  logic        accept;
  logic        res_vld;
  mfd_result_t res;
  mfd_result_t head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  assign accept = in_push && !in_full;

  mfd_front #(
    .LEN_BITS (LEN_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (accept),
    .rx_byte  (in_rx_byte),
    .max_len  (max_len_r),
    .res_vld  (res_vld),
    .res      (res)
  );

  mfd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_vld),
    .wr_data (res),
    .rd_en   (out_pop),
    .rd_data (head),
    .full    (in_full),
    .empty   (out_empty)
  );

  assign out_kind            = head.kind;
  assign out_data_byte       = head.data_byte;
  assign out_frame_len       = head.frame_len;
  assign out_is_command      = head.is_command;
  assign out_last_of_frame   = head.last_of_frame;
  assign out_last_of_message = head.last_of_message;

endmodule

// ===== tb/tb_message_frame_deframer.sv =====
// Self-checking testbench for message_frame_deframer: a queue-fed byte driver,
// a result monitor with its own frame parser prediction, and limit reprogramming.
// Depends on mfd_pkg and the message_frame_deframer RTL.
`timescale 1ns / 1ps

module tb_message_frame_deframer;
  import mfd_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 6;

  typedef enum logic [1:0] {EXP_FLAGS, EXP_SIZE, EXP_BODY} parse_phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_rx_byte = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic [15:0] out_frame_len;
  logic        out_is_command;
  logic        out_last_of_frame;
  logic        out_last_of_message;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  message_frame_deframer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_rx_byte          (in_rx_byte),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_kind            (out_kind),
    .out_data_byte       (out_data_byte),
    .out_frame_len       (out_frame_len),
    .out_is_command      (out_is_command),
    .out_last_of_frame   (out_last_of_frame),
    .out_last_of_message (out_last_of_message),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted parser state
  parse_phase_t frm_phase = EXP_FLAGS;
  logic [2:0]   frm_flags = '0;
  logic [3:0]   frm_size_left = '0;
  logic [63:0]  frm_size = '0;
  logic [15:0]  frm_body_left = '0;
  logic         frm_halted = 1'b0;
  logic [15:0]  frm_limit = MAX_LEN_RESET;

  logic [7:0]  link_bytes[$];
  mfd_result_t pending_results[$];
  int          queued_bytes = 0;
  int          errors = 0;
  int          results_seen = 0;
  int          cycles = 0;

  task automatic predict_rx(input logic [7:0] b);
    mfd_result_t r;
    logic        emit;
    logic        msg_end;
    r = '0;
    emit = 1'b0;
    msg_end = !frm_flags[FLAG_MORE_BIT];
    if (!frm_halted) begin
      case (frm_phase)
        EXP_FLAGS: begin
          frm_flags = b[2:0];
          frm_size_left = frm_flags[FLAG_LONG_BIT] ? 4'd8 : 4'd1;
          frm_size = '0;
          frm_phase = EXP_SIZE;
        end
        EXP_SIZE: begin
          frm_size = {frm_size[55:0], b};
          if (frm_size_left > 4'd1) begin
            frm_size_left--;
          end else begin
            frm_size_left = '0;
            emit = 1'b1;
            r.frame_len = (frm_size > 64'hFFFF) ? 16'hFFFF : frm_size[15:0];
            r.is_command = frm_flags[FLAG_CMD_BIT];
            if (frm_size > {48'd0, frm_limit}) begin
              frm_halted = 1'b1;
              frm_phase = EXP_FLAGS;
              r.kind = KIND_OVER;
            end else if (frm_size == 64'd0) begin
              frm_phase = EXP_FLAGS;
              r.kind = KIND_EMPTY;
              r.last_of_frame = 1'b1;
              r.last_of_message = msg_end;
            end else begin
              emit = 1'b0;
              frm_body_left = frm_size[15:0];
              frm_phase = EXP_BODY;
            end
          end
        end
        default: begin
          emit = 1'b1;
          r.kind = KIND_BYTE;
          r.data_byte = b;
          r.frame_len = frm_size[15:0];
          r.is_command = frm_flags[FLAG_CMD_BIT];
          if (frm_body_left <= 16'd1) begin
            frm_body_left = '0;
            frm_phase = EXP_FLAGS;
            r.last_of_frame = 1'b1;
            r.last_of_message = msg_end;
          end else begin
            frm_body_left--;
          end
        end
      endcase
    end
    if (emit) pending_results.push_back(r);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // sender: bursts of random length separated by random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    logic offer;
    offer = 1'b0;
    if (rst_n) begin
      if (in_push && !in_full) begin
        predict_rx(in_rx_byte);
        void'(link_bytes.pop_front());
      end
      if (in_push && in_full) begin
        offer = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (link_bytes.size() > 0) begin
        offer = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    in_push <= offer;
    if (offer) in_rx_byte <= link_bytes[0];
  end

  // receiver: a random stall mask, refreshed on a stall_ticks schedule, plus one long hold-off
  logic [15:0] stall_mask = '1;
  int          stall_ticks = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;

  always @(posedge clk) begin
    logic        take;
    mfd_result_t want;
    take = 1'b0;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none actual kind %0d", $time,
                   out_kind);
        end else begin
          want = pending_results.pop_front();
          check_field("kind", want.kind, out_kind);
          check_field("data_byte", want.data_byte, out_data_byte);
          check_field("frame_len", want.frame_len, out_frame_len);
          check_field("is_command", want.is_command, out_is_command);
          check_field("last_of_frame", want.last_of_frame, out_last_of_frame);
          check_field("last_of_message", want.last_of_message, out_last_of_message);
        end
      end
      if (stall_ticks % 32 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_mask = '1;
          1: stall_mask = 16'($urandom) & 16'($urandom);
          default: stall_mask = 16'($urandom);
        endcase
      end
      stall_ticks++;
      // hold off while the sender still has plenty queued, so the block backs up
      if (!hold_done && results_seen > 100 && link_bytes.size() > 40) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
      if (hold_left > 0) hold_left--;
      else take = stall_mask[stall_ticks % 16];
    end
    out_pop <= take;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_message_frame_deframer: errors");
      $finish;
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    link_bytes.push_back(b);
    queued_bytes++;
  endtask

  task automatic push_frame(input logic [7:0] flags_byte, input int len);
    logic [63:0] sz;
    sz = 64'(len);
    queue_byte(flags_byte);
    if (flags_byte[FLAG_LONG_BIT]) begin
      for (int i = 7; i >= 0; i--) queue_byte(sz[i*8 +: 8]);
    end else begin
      queue_byte(sz[7:0]);
    end
    for (int i = 0; i < len; i++) queue_byte(8'($urandom));
  endtask

  // well-formed frame within the current limit, mostly short bodies
  task automatic rand_frame();
    logic [7:0] flags_byte;
    int         len;
    int         cap;
    flags_byte = 8'($urandom);
    cap = int'(frm_limit);
    case ($urandom_range(0, 7))
      0: len = 0;
      1: len = (cap == 0) ? 0 : $urandom_range(1, (cap < 300) ? cap : 300);
      default: len = (cap == 0) ? 0 : $urandom_range(1, (cap < 12) ? cap : 12);
    endcase
    if (len > 255) flags_byte[FLAG_LONG_BIT] = 1'b1;
    push_frame(flags_byte, len);
  endtask

  task automatic wait_idle();
    while (link_bytes.size() != 0 || in_push || pending_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [15:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    frm_limit = value;
    @(negedge clk);
  endtask

  task automatic rand_phase(input int n);
    int start;
    start = queued_bytes;
    while (queued_bytes - start < n) rand_frame();
    wait_idle();
  endtask

  initial begin
    logic [7:0]  fb;
    logic [63:0] sz;
    int          lim;
    int          start;
    int          s;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, at the reset limit
    push_frame(8'h00, 1);
    link_bytes[link_bytes.size()-1] = 8'h00;
    // all flag bits set: long, command with more, unused bits ignored
    push_frame(8'hFF, 2);
    link_bytes[link_bytes.size()-2] = 8'hFF;
    link_bytes[link_bytes.size()-1] = 8'hAA;
    push_frame(8'h01, 0);
    push_frame(8'h04, 0);
    push_frame(8'h05, 2);
    link_bytes[link_bytes.size()-2] = 8'h55;
    link_bytes[link_bytes.size()-1] = 8'h80;
    push_frame(8'hF8, 1);
    link_bytes[link_bytes.size()-1] = 8'h7F;
    wait_idle();

    write_limit(16'd0);
    rand_phase(60);

    write_limit(16'd1);
    rand_phase(80);

    // leave a long frame waiting on its last size byte across a limit change
    fb = 8'($urandom);
    fb[FLAG_LONG_BIT] = 1'b1;
    queue_byte(fb);
    repeat (7) queue_byte(8'h00);
    wait_idle();
    write_limit(16'hFFFF);
    s = $urandom_range(0, 255);
    queue_byte(8'(s));
    for (int i = 0; i < s; i++) queue_byte(8'($urandom));
    rand_phase(120);

    write_limit(16'($urandom_range(2, 1000)));
    rand_phase(90);

    // bodies exactly at the limit
    lim = $urandom_range(2, 400);
    write_limit(16'(lim));
    start = queued_bytes;
    while (queued_bytes - start < 110) begin
      if ($urandom_range(0, 2) == 0) begin
        fb = 8'($urandom);
        if (lim > 255) fb[FLAG_LONG_BIT] = 1'b1;
        push_frame(fb, lim);
      end else begin
        rand_frame();
      end
    end
    wait_idle();

    // oversize, then everything after it is dropped
    lim = $urandom_range(0, 254);
    write_limit(16'(lim));
    rand_frame();
    if ($urandom_range(0, 1) == 0) begin
      fb = 8'($urandom);
      fb[FLAG_LONG_BIT] = 1'b0;
      push_frame(fb, $urandom_range(lim + 1, 255));
    end else begin
      fb = 8'($urandom);
      fb[FLAG_LONG_BIT] = 1'b1;
      queue_byte(fb);
      sz = {$urandom, $urandom};
      if (sz[63:16] == '0) sz[16] = 1'b1;
      for (int i = 7; i >= 0; i--) queue_byte(sz[i*8 +: 8]);
    end
    repeat (12) queue_byte(8'($urandom));
    wait_idle();

    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_message_frame_deframer: clean");
    end else begin
      $display("tb_message_frame_deframer: errors");
    end
    $finish;
  end

endmodule
